[src/cfp_pkg.sv]
// Shared types and constants for the converter fault protection block.
package cfp_pkg;

  localparam int NUM_CURRENTS = 5;
  localparam int CUR_W        = 16;
  localparam int LIMIT_W      = 15;
  localparam int BUS_W        = 12;
  localparam int DELAY_W      = 14;
  localparam int COUNT_W      = 4;
  localparam int FLAG_W       = 6;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 15;

  localparam logic [DELAY_W-1:0] TIMER_MAX = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [LIMIT_W-1:0] CURRENT_LIMIT_RST = 15'd2304;
  localparam logic [BUS_W-1:0]   BUS_LIMIT_RST     = 12'd3429;
  localparam logic               RECOVER_EN_RST    = 1'b1;
  localparam logic [DELAY_W-1:0] RECOVER_DELAY_RST = 14'd3000;
  localparam logic [COUNT_W-1:0] RETRY_LIMIT_RST   = 4'd3;

  localparam logic [1:0] STATUS_STOP  = 2'd0;
  localparam logic [1:0] STATUS_RUN   = 2'd1;
  localparam logic [1:0] STATUS_FAULT = 2'd2;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_RUN    = 2'd2,
    CMD_STOP   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_STOP  = 3'b001,
    ST_RUN   = 3'b010,
    ST_FAULT = 3'b100
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CURRENT_LIMIT = 3'd0,
    REG_BUS_LIMIT     = 3'd1,
    REG_RECOVER_EN    = 3'd2,
    REG_RECOVER_DELAY = 3'd3,
    REG_RETRY_LIMIT   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] current_limit;
    logic [BUS_W-1:0]   bus_limit_code;
    logic               recover_enable;
    logic [DELAY_W-1:0] recover_delay_ms;
    logic [COUNT_W-1:0] retry_limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         conv_mode;
    logic               pwm_enable;
    logic [FLAG_W-1:0]  trip_flags;
    logic [COUNT_W-1:0] retries_used;
  } result_t;

endpackage

[src/cfp_if.sv]
// Sample and result channel interfaces.
interface cfp_sample_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic signed [15:0] inv_u_current;
  logic signed [15:0] inv_v_current;
  logic signed [15:0] rec_w_current;
  logic signed [15:0] rec_u_current;
  logic signed [15:0] rec_v_current;
  logic [11:0]        bus_voltage_code;

  modport source (
    output valid, cmd, inv_u_current, inv_v_current, rec_w_current, rec_u_current,
    rec_v_current, bus_voltage_code,
    input  ready
  );
  modport sink (
    input  valid, cmd, inv_u_current, inv_v_current, rec_w_current, rec_u_current,
    rec_v_current, bus_voltage_code,
    output ready
  );
endinterface

interface cfp_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] conv_mode;
  logic       pwm_enable;
  logic [5:0] trip_flags;
  logic [3:0] retries_used;

  modport source (
    output valid, conv_mode, pwm_enable, trip_flags, retries_used,
    input  ready
  );
  modport sink (
    input  valid, conv_mode, pwm_enable, trip_flags, retries_used,
    output ready
  );
endinterface

[src/cfp_lane.sv]
// One current lane: magnitude of a signed Q8.8 sample against the trip limit.
module cfp_lane (
  input  logic signed [cfp_pkg::CUR_W-1:0]   current,
  input  logic        [cfp_pkg::LIMIT_W-1:0] limit,
  output logic                               trip
);
  logic [cfp_pkg::CUR_W:0] ext;
  logic [cfp_pkg::CUR_W:0] mag;

  assign ext  = {current[cfp_pkg::CUR_W-1], current};
  assign mag  = current[cfp_pkg::CUR_W-1] ? ((cfp_pkg::CUR_W+1)'(0) - ext) : ext;
  assign trip = mag > {{(cfp_pkg::CUR_W+1-cfp_pkg::LIMIT_W){1'b0}}, limit};
endmodule

[src/cfp_ctrl.sv]
// Merge of lane trips, bus check and the run/fault/stop state machine.
module cfp_ctrl (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               accept,
  input  cfp_pkg::cmd_t                      cmd,
  input  logic [cfp_pkg::NUM_CURRENTS-1:0]   lane_trips,
  input  logic [cfp_pkg::BUS_W-1:0]          bus_code,
  input  cfp_pkg::cfg_t                      cfg,
  output cfp_pkg::result_t                   res
);
  cfp_pkg::mode_t              mode, mode_next;
  logic [cfp_pkg::COUNT_W-1:0] retry_count, retry_count_next;
  logic [cfp_pkg::DELAY_W-1:0] delay_timer, delay_timer_next;
  logic [cfp_pkg::DELAY_W-1:0] timer_inc;
  logic [cfp_pkg::FLAG_W-1:0]  flags;
  logic                        bus_trip;
  logic                        limited;

  assign bus_trip  = (mode == cfp_pkg::ST_RUN) && (bus_code > cfg.bus_limit_code);
  assign limited   = cfg.retry_limit != '0;
  assign timer_inc = (delay_timer < cfp_pkg::TIMER_MAX) ? delay_timer + 1'b1 : delay_timer;

  always_comb begin
    mode_next        = mode;
    retry_count_next = retry_count;
    delay_timer_next = delay_timer;
    flags            = '0;
    unique case (cmd)
      cfp_pkg::CMD_SAMPLE: begin
        flags = {bus_trip, lane_trips};
        if (flags != '0) begin
          if (mode != cfp_pkg::ST_FAULT) begin
            delay_timer_next = '0;
          end
          mode_next = cfp_pkg::ST_FAULT;
        end
      end
      cfp_pkg::CMD_TICK: begin
        if (mode != cfp_pkg::ST_FAULT) begin
          delay_timer_next = '0;
        end else if (!cfg.recover_enable) begin
          mode_next        = cfp_pkg::ST_STOP;
          delay_timer_next = '0;
        end else if (limited && retry_count >= cfg.retry_limit) begin
          mode_next        = cfp_pkg::ST_STOP;
          retry_count_next = '0;
          delay_timer_next = '0;
        end else if (timer_inc >= cfg.recover_delay_ms) begin
          mode_next        = cfp_pkg::ST_RUN;
          delay_timer_next = '0;
          if (limited && retry_count < cfp_pkg::COUNT_MAX) begin
            retry_count_next = retry_count + 1'b1;
          end
        end else begin
          delay_timer_next = timer_inc;
        end
      end
      cfp_pkg::CMD_RUN: begin
        mode_next        = cfp_pkg::ST_RUN;
        delay_timer_next = '0;
      end
      cfp_pkg::CMD_STOP: begin
        mode_next        = cfp_pkg::ST_STOP;
        delay_timer_next = '0;
      end
      default: begin
        mode_next = mode;
      end
    endcase
  end

  always_comb begin
    unique case (mode_next)
      cfp_pkg::ST_RUN:   res.conv_mode = cfp_pkg::STATUS_RUN;
      cfp_pkg::ST_FAULT: res.conv_mode = cfp_pkg::STATUS_FAULT;
      default:           res.conv_mode = cfp_pkg::STATUS_STOP;
    endcase
    res.pwm_enable   = mode_next == cfp_pkg::ST_RUN;
    res.trip_flags   = flags;
    res.retries_used = retry_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= cfp_pkg::ST_STOP;
      retry_count <= '0;
      delay_timer <= '0;
    end else if (accept) begin
      mode        <= mode_next;
      retry_count <= retry_count_next;
      delay_timer <= delay_timer_next;
    end
  end
endmodule

[src/converter_fault_protection_top.sv]
// Top level of the converter fault protection block.
// Usage:
//   sample: command items (sample, millisecond tick, run, stop) with five phase
//     currents and the bus ADC code; an item is taken when valid and ready are high.
//   result: one item per input item: mode, gate enable, trip flags, retry count.
//   cfg_we/cfg_index/cfg_data: register writes, one per cycle, only while idle.
// A result is registered and becomes valid in the cycle after its item is taken.
// Throughput: one item per cycle unless a result is stalled; five current lanes
//   compare in parallel; the state update finishes in the cycle the item is taken.
// The single output register sets the rate: sample.ready stays high while the
//   register is empty or being drained, so a stalled receiver holds the result
//   and stops new items until it takes it.
// Reset: mode goes to stop, retry count and delay timer clear, registers take
//   their default values, and the output register empties.
module converter_fault_protection_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [cfp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cfp_pkg::CFG_DATA_W-1:0]   cfg_data,
  cfp_sample_if.sink                       sample,
  cfp_result_if.source                     result
);
  cfp_pkg::cfg_t                       cfg;
  cfp_pkg::result_t                    res_next;
  cfp_pkg::result_t                    res;
  logic                                res_valid;
  logic                                accept;
  logic signed [cfp_pkg::CUR_W-1:0]    currents [cfp_pkg::NUM_CURRENTS];
  logic [cfp_pkg::NUM_CURRENTS-1:0]    lane_trips;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.current_limit    <= cfp_pkg::CURRENT_LIMIT_RST;
      cfg.bus_limit_code   <= cfp_pkg::BUS_LIMIT_RST;
      cfg.recover_enable   <= cfp_pkg::RECOVER_EN_RST;
      cfg.recover_delay_ms <= cfp_pkg::RECOVER_DELAY_RST;
      cfg.retry_limit      <= cfp_pkg::RETRY_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfp_pkg::reg_idx_t'(cfg_index))
        cfp_pkg::REG_CURRENT_LIMIT: cfg.current_limit    <= cfg_data[cfp_pkg::LIMIT_W-1:0];
        cfp_pkg::REG_BUS_LIMIT:     cfg.bus_limit_code   <= cfg_data[cfp_pkg::BUS_W-1:0];
        cfp_pkg::REG_RECOVER_EN:    cfg.recover_enable   <= cfg_data[0];
        cfp_pkg::REG_RECOVER_DELAY: cfg.recover_delay_ms <= cfg_data[cfp_pkg::DELAY_W-1:0];
        cfp_pkg::REG_RETRY_LIMIT:   cfg.retry_limit      <= cfg_data[cfp_pkg::COUNT_W-1:0];
        default:                    cfg.retry_limit      <= cfg.retry_limit;
      endcase
    end
  end

  assign sample.ready = !res_valid || result.ready;
  assign accept       = sample.valid && sample.ready;

  assign currents[0] = sample.inv_u_current;
  assign currents[1] = sample.inv_v_current;
  assign currents[2] = sample.rec_w_current;
  assign currents[3] = sample.rec_u_current;
  assign currents[4] = sample.rec_v_current;

  for (genvar g = 0; g < cfp_pkg::NUM_CURRENTS; g++) begin : g_lane
    cfp_lane u_lane (
      .current (currents[g]),
      .limit   (cfg.current_limit),
      .trip    (lane_trips[g])
    );
  end

  cfp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .cmd        (cfp_pkg::cmd_t'(sample.cmd)),
    .lane_trips (lane_trips),
    .bus_code   (sample.bus_voltage_code),
    .cfg        (cfg),
    .res        (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  assign result.valid        = res_valid;
  assign result.conv_mode    = res.conv_mode;
  assign result.pwm_enable   = res.pwm_enable;
  assign result.trip_flags   = res.trip_flags;
  assign result.retries_used = res.retries_used;
endmodule

[src/cfp_checker.sv]
// Port-level checks for the converter fault protection block, bound to the top.
module cfp_checker (
  input logic       clk,
  input logic       rst,
  input logic       sample_valid,
  input logic       sample_ready,
  input logic       result_valid,
  input logic       result_ready,
  input logic [1:0] conv_mode,
  input logic       pwm_enable,
  input logic [5:0] trip_flags
);
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(conv_mode)
      && $stable(trip_flags))
    else $error("stalled result changed");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !sample_ready |-> result_valid && !result_ready)
    else $error("sample stalled without a blocked result");

  a_pwm: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> pwm_enable == (conv_mode == cfp_pkg::STATUS_RUN))
    else $error("gate enable disagrees with mode");

  a_trip_fault: assert property (@(posedge clk) disable iff (rst)
    result_valid && trip_flags != 6'd0 |-> conv_mode == cfp_pkg::STATUS_FAULT)
    else $error("trip without fault mode");
endmodule

bind converter_fault_protection_top cfp_checker u_cfp_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample.valid),
  .sample_ready (sample.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .conv_mode    (result.conv_mode),
  .pwm_enable   (result.pwm_enable),
  .trip_flags   (result.trip_flags)
);

[tb/sv/converter_fault_protection_top_test.sv]
// Testbench for the converter fault protection top: directed table, then random commands.
`timescale 1ns / 100ps

module converter_fault_protection_top_test;

  typedef struct packed {
    cfp_pkg::cmd_t                                                cmd;
    logic [cfp_pkg::NUM_CURRENTS-1:0][cfp_pkg::CUR_W-1:0]         cur;
    logic [cfp_pkg::BUS_W-1:0]                                    bus;
  } sample_item_t;

  typedef struct packed {
    sample_item_t     item;
    logic             has_want;
    cfp_pkg::result_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst;
  logic                           cfg_we;
  logic [cfp_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [cfp_pkg::CFG_DATA_W-1:0] cfg_data;

  cfp_sample_if sample_ch();
  cfp_result_if result_ch();

  converter_fault_protection_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample_ch),
    .result    (result_ch)
  );

  // protection predictor state and registers
  logic [cfp_pkg::LIMIT_W-1:0] lim_current = cfp_pkg::CURRENT_LIMIT_RST;
  logic [cfp_pkg::BUS_W-1:0]   lim_bus     = cfp_pkg::BUS_LIMIT_RST;
  logic                        rec_en      = cfp_pkg::RECOVER_EN_RST;
  logic [cfp_pkg::DELAY_W-1:0] rec_delay   = cfp_pkg::RECOVER_DELAY_RST;
  logic [cfp_pkg::COUNT_W-1:0] retry_lim   = cfp_pkg::RETRY_LIMIT_RST;
  logic [1:0]                  mode_q      = cfp_pkg::STATUS_STOP;
  logic [cfp_pkg::COUNT_W-1:0] retry_cnt   = '0;
  logic [cfp_pkg::DELAY_W-1:0] fault_ms    = '0;

  cfp_pkg::result_t pending_status[$];
  row_t             dir_rows[$];

  int send_gap_pct = 35;
  int recv_gap_pct = 50;
  int mismatches   = 0;
  int items_sent   = 0;
  int results_seen = 0;
  int trips_seen   = 0;
  int restarts     = 0;
  int give_ups     = 0;
  int settings     = 1;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void ms_tick();
    if (mode_q != cfp_pkg::STATUS_FAULT) begin
      fault_ms = '0;
    end else if (!rec_en) begin
      mode_q   = cfp_pkg::STATUS_STOP;
      fault_ms = '0;
    end else if (retry_lim != 0 && retry_cnt >= retry_lim) begin
      mode_q    = cfp_pkg::STATUS_STOP;
      retry_cnt = '0;
      fault_ms  = '0;
      give_ups++;
    end else begin
      if (fault_ms != cfp_pkg::TIMER_MAX) fault_ms = fault_ms + 1'b1;
      if (fault_ms >= rec_delay) begin
        mode_q   = cfp_pkg::STATUS_RUN;
        fault_ms = '0;
        restarts++;
        if (retry_lim != 0 && retry_cnt != cfp_pkg::COUNT_MAX) retry_cnt = retry_cnt + 1'b1;
      end
    end
  endfunction

  function automatic cfp_pkg::result_t protect_step(sample_item_t it);
    cfp_pkg::result_t           r;
    logic [cfp_pkg::FLAG_W-1:0] flags;
    logic [cfp_pkg::CUR_W:0]    mag;
    flags = '0;
    case (it.cmd)
      cfp_pkg::CMD_SAMPLE: begin
        for (int i = 0; i < cfp_pkg::NUM_CURRENTS; i++) begin
          mag = it.cur[i][cfp_pkg::CUR_W-1] ? (17'h10000 - {1'b0, it.cur[i]})
                                            : {1'b0, it.cur[i]};
          if (mag > {2'b00, lim_current}) flags[i] = 1'b1;
        end
        if (mode_q == cfp_pkg::STATUS_RUN && it.bus > lim_bus)
          flags[cfp_pkg::NUM_CURRENTS] = 1'b1;
        if (flags != 0) begin
          if (mode_q != cfp_pkg::STATUS_FAULT) fault_ms = '0;
          mode_q = cfp_pkg::STATUS_FAULT;
          trips_seen++;
        end
      end
      cfp_pkg::CMD_TICK: ms_tick();
      cfp_pkg::CMD_RUN: begin
        mode_q   = cfp_pkg::STATUS_RUN;
        fault_ms = '0;
      end
      default: begin
        mode_q   = cfp_pkg::STATUS_STOP;
        fault_ms = '0;
      end
    endcase
    r.conv_mode    = mode_q;
    r.pwm_enable   = (mode_q == cfp_pkg::STATUS_RUN);
    r.trip_flags   = flags;
    r.retries_used = retry_cnt;
    return r;
  endfunction

  function automatic row_t drow(cfp_pkg::cmd_t c, logic [15:0] u, logic [15:0] v,
                                logic [15:0] w, logic [15:0] ru, logic [15:0] rv,
                                logic [cfp_pkg::BUS_W-1:0] bus, logic has_want,
                                logic [1:0] mode, logic [cfp_pkg::FLAG_W-1:0] flags);
    row_t r;
    r.item.cmd          = c;
    r.item.cur          = {rv, ru, w, v, u};
    r.item.bus          = bus;
    r.has_want          = has_want;
    r.want.conv_mode    = mode;
    r.want.pwm_enable   = (mode == cfp_pkg::STATUS_RUN);
    r.want.trip_flags   = flags;
    r.want.retries_used = '0;
    return r;
  endfunction

  function automatic sample_item_t random_item(int tick_pct, int ctl_pct, int trip_pct);
    sample_item_t it;
    int           r;
    logic [15:0]  mag;
    r = int'($urandom_range(99));
    if (r < tick_pct) it.cmd = cfp_pkg::CMD_TICK;
    else if (r < tick_pct + ctl_pct)
      it.cmd = $urandom_range(1) ? cfp_pkg::CMD_RUN : cfp_pkg::CMD_STOP;
    else it.cmd = cfp_pkg::CMD_SAMPLE;
    for (int i = 0; i < cfp_pkg::NUM_CURRENTS; i++) begin
      r = int'($urandom_range(99));
      if (r < trip_pct) begin
        it.cur[i] = 16'($urandom);
      end else begin
        if (r < trip_pct + 3) mag = {1'b0, lim_current} + 16'($urandom_range(1));
        else mag = 16'($urandom_range(lim_current, 0));
        it.cur[i] = $urandom_range(1) ? -mag : mag;
      end
    end
    if ($urandom_range(1)) it.bus = 12'($urandom);
    else it.bus = lim_bus - 1'b1 + 12'($urandom_range(2));
    return it;
  endfunction

  task automatic send_item(input sample_item_t it, input logic has_want,
                           input cfp_pkg::result_t want);
    cfp_pkg::result_t predicted;
    while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      sample_ch.valid <= 1'b0;
      @(negedge clk);
    end
    sample_ch.valid            <= 1'b1;
    sample_ch.cmd              <= it.cmd;
    sample_ch.inv_u_current    <= it.cur[0];
    sample_ch.inv_v_current    <= it.cur[1];
    sample_ch.rec_w_current    <= it.cur[2];
    sample_ch.rec_u_current    <= it.cur[3];
    sample_ch.rec_v_current    <= it.cur[4];
    sample_ch.bus_voltage_code <= it.bus;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    predicted = protect_step(it);
    pending_status.push_back(has_want ? want : predicted);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    sample_ch.valid <= 1'b0;
    while (pending_status.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [cfp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [cfp_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      cfp_pkg::REG_CURRENT_LIMIT: lim_current = data[cfp_pkg::LIMIT_W-1:0];
      cfp_pkg::REG_BUS_LIMIT:     lim_bus     = data[cfp_pkg::BUS_W-1:0];
      cfp_pkg::REG_RECOVER_EN:    rec_en      = data[0];
      cfp_pkg::REG_RECOVER_DELAY: rec_delay   = data[cfp_pkg::DELAY_W-1:0];
      cfp_pkg::REG_RETRY_LIMIT:   retry_lim   = data[cfp_pkg::COUNT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic run_phase(input logic [cfp_pkg::CFG_DATA_W-1:0] cur_lim,
                           input logic [cfp_pkg::CFG_DATA_W-1:0] bus_lim,
                           input logic [cfp_pkg::CFG_DATA_W-1:0] en,
                           input logic [cfp_pkg::CFG_DATA_W-1:0] dly,
                           input logic [cfp_pkg::CFG_DATA_W-1:0] rlim,
                           input logic poke_unused,
                           input int n, input int tick_pct, input int ctl_pct,
                           input int trip_pct, input int sgap, input int rgap);
    wait_idle();
    write_reg(cfp_pkg::REG_CURRENT_LIMIT, cur_lim);
    write_reg(cfp_pkg::REG_BUS_LIMIT, bus_lim);
    write_reg(cfp_pkg::REG_RECOVER_EN, en);
    write_reg(cfp_pkg::REG_RECOVER_DELAY, dly);
    write_reg(cfp_pkg::REG_RETRY_LIMIT, rlim);
    if (poke_unused) begin
      for (int k = int'(cfp_pkg::REG_RETRY_LIMIT) + 1; k < 2 ** cfp_pkg::CFG_IDX_W; k++) begin
        write_reg(k[cfp_pkg::CFG_IDX_W-1:0], 15'($urandom));
      end
    end
    cfg_we <= 1'b0;
    send_gap_pct = sgap;
    recv_gap_pct = rgap;
    settings++;
    for (int k = 0; k < n; k++) begin
      if (k == n / 2 || $urandom_range(199) == 0) wait_idle();
      send_item(random_item(tick_pct, ctl_pct, trip_pct), 1'b0, '0);
    end
  endtask

  always @(negedge clk) begin
    result_ch.ready <= ($urandom_range(99) >= recv_gap_pct);
  end

  always @(posedge clk) begin : status_check
    cfp_pkg::result_t want;
    cfp_pkg::result_t got;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got.conv_mode    = result_ch.conv_mode;
      got.pwm_enable   = result_ch.pwm_enable;
      got.trip_flags   = result_ch.trip_flags;
      got.retries_used = result_ch.retries_used;
      results_seen++;
      if (pending_status.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: mode %0d pwm %0b flags %02h retries %0d",
                   got.conv_mode, got.pwm_enable, got.trip_flags, got.retries_used);
      end else begin
        want = pending_status.pop_front();
        if (got.conv_mode !== want.conv_mode || got.pwm_enable !== want.pwm_enable ||
            got.trip_flags !== want.trip_flags || got.retries_used !== want.retries_used) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"result %0d: want mode %0d pwm %0b flags %02h retries %0d,",
                      " got mode %0d pwm %0b flags %02h retries %0d"},
                     results_seen, want.conv_mode, want.pwm_enable, want.trip_flags,
                     want.retries_used, got.conv_mode, got.pwm_enable, got.trip_flags,
                     got.retries_used);
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    row_t r;
    rst                        = 1'b1;
    cfg_we                     = 1'b0;
    cfg_index                  = '0;
    cfg_data                   = '0;
    sample_ch.valid            = 1'b0;
    sample_ch.cmd              = cfp_pkg::CMD_SAMPLE;
    sample_ch.inv_u_current    = '0;
    sample_ch.inv_v_current    = '0;
    sample_ch.rec_w_current    = '0;
    sample_ch.rec_u_current    = '0;
    sample_ch.rec_v_current    = '0;
    sample_ch.bus_voltage_code = '0;

    dir_rows.push_back(drow(cfp_pkg::CMD_SAMPLE, 0, 0, 0, 0, 0, 0, 1,
                            cfp_pkg::STATUS_STOP, 6'h00));
    dir_rows.push_back(drow(cfp_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0, 1,
                            cfp_pkg::STATUS_STOP, 6'h00));
    dir_rows.push_back(drow(cfp_pkg::CMD_SAMPLE, 2304, 2304, 2304, 2304, 2304, 4095, 1,
                            cfp_pkg::STATUS_STOP, 6'h00));
    dir_rows.push_back(drow(cfp_pkg::CMD_RUN, 0, 0, 0, 0, 0, 0, 1,
                            cfp_pkg::STATUS_RUN, 6'h00));
    dir_rows.push_back(drow(cfp_pkg::CMD_SAMPLE, 2304, -16'sd2304, 2304, -16'sd2304, 0, 3429, 1,
                            cfp_pkg::STATUS_RUN, 6'h00));
    dir_rows.push_back(drow(cfp_pkg::CMD_SAMPLE, 0, 0, 0, 0, 0, 3430, 1,
                            cfp_pkg::STATUS_FAULT, 6'h20));
    dir_rows.push_back(drow(cfp_pkg::CMD_SAMPLE, 2305, 0, 0, 0, 0, 4095, 1,
                            cfp_pkg::STATUS_FAULT, 6'h01));
    dir_rows.push_back(drow(cfp_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0, 1,
                            cfp_pkg::STATUS_FAULT, 6'h00));
    dir_rows.push_back(drow(cfp_pkg::CMD_RUN, 0, 0, 0, 0, 0, 0, 1,
                            cfp_pkg::STATUS_RUN, 6'h00));
    dir_rows.push_back(drow(cfp_pkg::CMD_SAMPLE, 0, -16'sd2305, 0, 0, 0, 0, 1,
                            cfp_pkg::STATUS_FAULT, 6'h02));
    dir_rows.push_back(drow(cfp_pkg::CMD_STOP, 0, 0, 0, 0, 0, 0, 1,
                            cfp_pkg::STATUS_STOP, 6'h00));
    dir_rows.push_back(drow(cfp_pkg::CMD_SAMPLE, 0, 0, 16'h7FFF, 0, 0, 0, 1,
                            cfp_pkg::STATUS_FAULT, 6'h04));
    dir_rows.push_back(drow(cfp_pkg::CMD_STOP, 0, 0, 0, 0, 0, 0, 0,
                            cfp_pkg::STATUS_STOP, 6'h00));
    dir_rows.push_back(drow(cfp_pkg::CMD_SAMPLE, 0, 0, 0, 16'h8000, 0, 0, 1,
                            cfp_pkg::STATUS_FAULT, 6'h08));
    dir_rows.push_back(drow(cfp_pkg::CMD_RUN, 0, 0, 0, 0, 0, 0, 0,
                            cfp_pkg::STATUS_STOP, 6'h00));
    dir_rows.push_back(drow(cfp_pkg::CMD_SAMPLE, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                            16'h8000, 4095, 1, cfp_pkg::STATUS_FAULT, 6'h3F));
    dir_rows.push_back(drow(cfp_pkg::CMD_RUN, 0, 0, 0, 0, 0, 0, 0,
                            cfp_pkg::STATUS_STOP, 6'h00));
    dir_rows.push_back(drow(cfp_pkg::CMD_SAMPLE, 0, 0, 0, 0, 16'h7FFF, 4095, 1,
                            cfp_pkg::STATUS_FAULT, 6'h30));
    dir_rows.push_back(drow(cfp_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0, 0,
                            cfp_pkg::STATUS_STOP, 6'h00));
    dir_rows.push_back(drow(cfp_pkg::CMD_STOP, 0, 0, 0, 0, 0, 0, 0,
                            cfp_pkg::STATUS_STOP, 6'h00));
    dir_rows.push_back(drow(cfp_pkg::CMD_SAMPLE, 16'h8001, 16'h8001, 16'h8001, 16'h8001,
                            16'h8001, 4095, 1, cfp_pkg::STATUS_FAULT, 6'h1F));
    dir_rows.push_back(drow(cfp_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0, 0,
                            cfp_pkg::STATUS_STOP, 6'h00));
    dir_rows.push_back(drow(cfp_pkg::CMD_STOP, 0, 0, 0, 0, 0, 0, 1,
                            cfp_pkg::STATUS_STOP, 6'h00));

    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      send_item(r.item, r.has_want, r.want);
    end

    run_phase(2304, 3429, 1, 3, 3, 0, 400, 35, 10, 3, 35, 50);
    run_phase(0, 0, 1, 1, 0, 0, 200, 40, 10, 3, 35, 50);
    run_phase(32767, 4095, 1, 0, 15, 0, 200, 30, 10, 5, 50, 35);
    run_phase(15'($urandom_range(32767)), 15'($urandom_range(4095)), 15'h7FFE, 5, 2, 1,
              200, 35, 10, 3, 50, 35);
    run_phase(1500, 3000, 1, 400, 1, 0, 700, 85, 0, 0, 0, 0);
    run_phase(2304, 3429, 1, 2, 10, 0, 250, 35, 10, 3, 0, 0);
    run_phase(2304, 3429, 1, 10000, 0, 0, 100, 35, 10, 3, 0, 0);

    wait_idle();
    repeat (4) @(posedge clk);
    $display("Sent %0d items (%0d directed) under %0d register settings, %0d results checked",
             items_sent, dir_rows.size(), settings, results_seen);
    $display("Predicted %0d trips, %0d automatic restarts and %0d give-ups to stop",
             trips_seen, restarts, give_ups);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
